>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl, used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define DBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication, off during reset
`define DBS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/dbs_pkg.sv
// package: constants and types of the point clustering block
`default_nettype none
package dbs_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LABEL_W    = 12;
  localparam int EPS_W      = 16;
  localparam int MINNB_W    = 11;
  localparam int RIDX_W     = 10;
  localparam int TOT_W      = 11;
  localparam int PT_W       = 3 * COORD_W;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SUM_W      = SQ_W + 2;

  localparam logic [LABEL_W-1:0] NOISE_LABEL = '1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_EPS   = 1'b0;
  localparam logic REG_MINNB = 1'b1;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      final_point;
    logic [RIDX_W-1:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [LABEL_W-1:0] point_label;
    logic [TOT_W-1:0]          cluster_total;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pt_addr;
    logic [IDX_W-1:0]   lab_addr;
    logic               lab_we;
    logic [IDX_W-1:0]   lab_waddr;
    logic [LABEL_W-1:0] lab_wdata;
    logic               scan_v;
    logic [IDX_W-1:0]   scan_k;
    logic               p_load;
  } eng_req_t;

  typedef struct packed {
    logic               v;
    logic [IDX_W-1:0]   k;
    logic [LABEL_W-1:0] lab;
    logic               near;
  } dist_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/dbs_dist.sv
// distance pipeline: neighbor test of streamed points against a center point
`default_nettype none
module dbs_dist (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [dbs_pkg::EPS_W-1:0]  eps,
  input  wire logic                       scan_v,
  input  wire logic [dbs_pkg::IDX_W-1:0]  scan_k,
  input  wire logic                       p_load,
  input  wire logic [dbs_pkg::PT_W-1:0]   pt_data,
  input  wire logic [dbs_pkg::LABEL_W-1:0] lab_data,
  output dbs_pkg::dist_res_t              res,
  output logic                            active
);
  import dbs_pkg::*;

  logic [PT_W-1:0]    p_r;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]   k1_r, k2_r, k3_r, k4_r;
  logic [LABEL_W-1:0] lab2_r, lab3_r, lab4_r;
  logic [COORD_W-1:0] ad_r [3];
  logic [SQ_W-1:0]    sq_r [3];
  logic               near_r;
  logic [SQ_W-1:0]    eps_sq_r;
  logic [COORD_W:0]   dif [3];
  logic [COORD_W:0]   mag [3];
  logic [SUM_W-1:0]   sum;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dif[j] = {pt_data[(3-j)*COORD_W-1], pt_data[(3-j)*COORD_W-1 -: COORD_W]}
             - {p_r[(3-j)*COORD_W-1], p_r[(3-j)*COORD_W-1 -: COORD_W]};
      mag[j] = dif[j][COORD_W] ? (~dif[j] + 1'b1) : dif[j];
    end
    sum = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= scan_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    eps_sq_r <= eps * eps;
    if (p_load) begin
      p_r <= pt_data;
    end
    k1_r   <= scan_k;
    k2_r   <= k1_r;
    lab2_r <= lab_data;
    for (int j = 0; j < 3; j++) begin
      ad_r[j] <= mag[j][COORD_W-1:0];
      sq_r[j] <= ad_r[j] * ad_r[j];
    end
    k3_r   <= k2_r;
    lab3_r <= lab2_r;
    k4_r   <= k3_r;
    lab4_r <= lab3_r;
    near_r <= (sum <= {2'b00, eps_sq_r});
  end

  assign res.v    = v4_r;
  assign res.k    = k4_r;
  assign res.lab  = lab4_r;
  assign res.near = near_r;
  assign active   = v1_r | v2_r | v3_r | v4_r;

endmodule
`default_nettype wire

>>> hw/rtl/dbs_engine.sv
// clustering sequencer with the expansion queue memory
`default_nettype none
module dbs_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start_run,
  input  wire logic [dbs_pkg::CNT_W-1:0]   total,
  input  wire logic [dbs_pkg::MINNB_W-1:0] min_nb,
  input  wire logic [dbs_pkg::LABEL_W-1:0] lab_rd_data,
  input  dbs_pkg::dist_res_t               res,
  input  wire logic                        pipe_active,
  output dbs_pkg::eng_req_t                req,
  output logic                             eng_busy,
  output logic [dbs_pkg::CNT_W-1:0]        clusters
);
  import dbs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SEED_RD  = 10'b0000000010,
    S_SEED_CHK = 10'b0000000100,
    S_PT_RD    = 10'b0000001000,
    S_PT_CAP   = 10'b0000010000,
    S_SCAN     = 10'b0000100000,
    S_DECIDE   = 10'b0001000000,
    S_Q_CHK    = 10'b0010000000,
    S_Q_CAP    = 10'b0100000000,
    S_NEXT     = 10'b1000000000
  } st_t;

  st_t                st_r, st_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, c_r, c_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt, cnt_r, cnt_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]   clusters_r, clusters_nxt;
  logic [LABEL_W-1:0] id_r, id_nxt;
  logic               claim_r, claim_nxt, seed_r, seed_nxt;
  logic               q_we;
  logic [IDX_W-1:0]   qmem [MAX_POINTS];
  logic [IDX_W-1:0]   q_rd_r;
  logic [LABEL_W-1:0] id_dec;

  assign id_dec = id_r - 1'b1;

  always_comb begin
    st_nxt       = st_r;
    i_nxt        = i_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    clusters_nxt = clusters_r;
    id_nxt       = id_r;
    claim_nxt    = claim_r;
    seed_nxt     = seed_r;
    q_we         = 1'b0;
    req.pt_addr   = c_r;
    req.lab_addr  = i_r;
    req.lab_we    = 1'b0;
    req.lab_waddr = res.k;
    req.lab_wdata = id_r;
    req.scan_v    = 1'b0;
    req.scan_k    = k_r[IDX_W-1:0];
    req.p_load    = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (start_run) begin
          i_nxt  = '0;
          id_nxt = LABEL_W'(1);
          st_nxt = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        st_nxt = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        if (lab_rd_data != '0) begin
          st_nxt = S_NEXT;
        end else begin
          c_nxt    = i_r;
          seed_nxt = 1'b1;
          st_nxt   = S_PT_RD;
        end
      end
      S_PT_RD: begin
        st_nxt = S_PT_CAP;
      end
      S_PT_CAP: begin
        req.p_load = 1'b1;
        cnt_nxt    = '0;
        k_nxt      = '0;
        claim_nxt  = 1'b0;
        st_nxt     = S_SCAN;
      end
      S_SCAN: begin
        req.pt_addr  = k_r[IDX_W-1:0];
        req.lab_addr = k_r[IDX_W-1:0];
        if (k_r < total) begin
          req.scan_v = 1'b1;
          k_nxt      = k_r + 1'b1;
        end
        if (res.v && res.near) begin
          if (!claim_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end else if (res.lab == '0) begin
            req.lab_we = 1'b1;
            q_we       = 1'b1;
            tail_nxt   = tail_r + 1'b1;
          end
        end
        if (k_r >= total && !pipe_active) begin
          st_nxt = claim_r ? S_Q_CHK : S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (seed_r) begin
          req.lab_we    = 1'b1;
          req.lab_waddr = i_r;
          if (cnt_r < min_nb) begin
            req.lab_wdata = NOISE_LABEL;
            st_nxt        = S_NEXT;
          end else begin
            head_nxt  = '0;
            tail_nxt  = '0;
            claim_nxt = 1'b1;
            k_nxt     = '0;
            st_nxt    = S_SCAN;
          end
        end else if (cnt_r >= min_nb) begin
          claim_nxt = 1'b1;
          k_nxt     = '0;
          st_nxt    = S_SCAN;
        end else begin
          st_nxt = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (head_r < tail_r) begin
          head_nxt = head_r + 1'b1;
          st_nxt   = S_Q_CAP;
        end else begin
          id_nxt = id_r + 1'b1;
          st_nxt = S_NEXT;
        end
      end
      S_Q_CAP: begin
        c_nxt    = q_rd_r;
        seed_nxt = 1'b0;
        st_nxt   = S_PT_RD;
      end
      S_NEXT: begin
        if ({1'b0, i_r} + 1'b1 >= total) begin
          clusters_nxt = id_dec[CNT_W-1:0];
          st_nxt       = S_IDLE;
        end else begin
          i_nxt  = i_r + 1'b1;
          st_nxt = S_SEED_RD;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      clusters_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      claim_r    <= 1'b0;
      seed_r     <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clusters_r <= clusters_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      claim_r    <= claim_nxt;
      seed_r     <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    c_r   <= c_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    id_r  <= id_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[tail_r[IDX_W-1:0]] <= res.k;
    end
    q_rd_r <= qmem[head_r[IDX_W-1:0]];
  end

  assign eng_busy = (st_r != S_IDLE);
  assign clusters = clusters_r;

endmodule
`default_nettype wire

>>> hw/rtl/dbscan_point_clustering.sv
// top level: point and label memories, command port and configuration
//
// channel  | ports                       | handshake
// input    | start, busy, in_item        | taken when start & !busy
// result   | out_valid, out_item         | one-cycle strobe, no stall
// config   | cfg_we, cfg_index, cfg_data | taken when cfg_we
//
// loads and label reads are taken back to back while idle
// a read result is strobed in the cycle after the read is taken; the receiver cannot stall
// a final load starts the run and busy holds off every item until it ends
// each center: fetch, a count scan over all n points, and for a core center a
//   claim scan over all n points
// reset clears control state and sets eps and min_nb to defaults; memories fill through loads
`default_nettype none
`include "assert_macros.svh"
module dbscan_point_clustering (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  dbs_pkg::in_item_t                in_item,
  output logic                             out_valid,
  output dbs_pkg::out_item_t               out_item,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [dbs_pkg::EPS_W-1:0]   cfg_data
);
  import dbs_pkg::*;

  logic [EPS_W-1:0]   eps_r;
  logic [MINNB_W-1:0] minnb_r;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic               closed_r, closed_nxt;
  logic               out_valid_r, hit_r;
  logic               acc, acc_load, acc_read, room, pt_we, start_run, eng_busy, pipe_active;
  logic [IDX_W-1:0]   ld_addr, lab_raddr, lab_waddr;
  logic               lab_we;
  logic [LABEL_W-1:0] lab_wdata;
  logic [PT_W-1:0]    pmem [MAX_POINTS];
  logic [LABEL_W-1:0] lmem [MAX_POINTS];
  logic [PT_W-1:0]    pt_rd_r;
  logic [LABEL_W-1:0] lab_rd_r;
  logic [CNT_W-1:0]   clusters;
  eng_req_t           req;
  dist_res_t          res;

  assign busy      = eng_busy;
  assign acc       = start & ~eng_busy;
  assign acc_load  = acc & (in_item.command == CMD_LOAD);
  assign acc_read  = acc & (in_item.command == CMD_READ);
  assign ld_addr   = closed_r ? '0 : total_r[IDX_W-1:0];
  assign room      = closed_r || (total_r < CNT_W'(MAX_POINTS));
  assign pt_we     = acc_load & room;
  assign start_run = acc_load & in_item.final_point;

  always_comb begin
    total_nxt  = total_r;
    closed_nxt = closed_r;
    if (acc_load) begin
      if (closed_r) begin
        total_nxt = CNT_W'(1);
      end else if (room) begin
        total_nxt = total_r + 1'b1;
      end
      closed_nxt = in_item.final_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= EPS_W'(256);
      minnb_r     <= MINNB_W'(10);
      total_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_EPS) begin
        eps_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_MINNB) begin
        minnb_r <= cfg_data[MINNB_W-1:0];
      end
      total_r     <= total_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= acc_read;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= (CNT_W'(in_item.read_index) < total_r);
  end

  assign lab_raddr = eng_busy ? req.lab_addr : IDX_W'(in_item.read_index);
  assign lab_we    = pt_we | req.lab_we;
  assign lab_waddr = eng_busy ? req.lab_waddr : ld_addr;
  assign lab_wdata = eng_busy ? req.lab_wdata : '0;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pmem[ld_addr] <= {in_item.coord_x, in_item.coord_y, in_item.coord_z};
    end
    pt_rd_r <= pmem[req.pt_addr];
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      lmem[lab_waddr] <= lab_wdata;
    end
    lab_rd_r <= lmem[lab_raddr];
  end

  dbs_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_run  (start_run),
    .total      (total_r),
    .min_nb     (minnb_r),
    .lab_rd_data(lab_rd_r),
    .res        (res),
    .pipe_active(pipe_active),
    .req        (req),
    .eng_busy   (eng_busy),
    .clusters   (clusters)
  );

  dbs_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .eps     (eps_r),
    .scan_v  (req.scan_v),
    .scan_k  (req.scan_k),
    .p_load  (req.p_load),
    .pt_data (pt_rd_r),
    .lab_data(lab_rd_r),
    .res     (res),
    .active  (pipe_active)
  );

  assign out_valid              = out_valid_r;
  assign out_item.point_label   = hit_r ? lab_rd_r : '0;
  assign out_item.cluster_total = clusters[TOT_W-1:0];

  `DBS_ASSERT(a_out_after_read, out_valid |-> $past(acc_read), "result without a read item")
  `DBS_ASSERT(a_run_on_final, $rose(busy) |-> $past(start_run), "run began without a final load")
  `DBS_IMPLY(a_scan_only_busy, req.scan_v || res.v, eng_busy, "scan outside a run")

endmodule
`default_nettype wire

>>> sim/dbscan_point_clustering_tb.sv
// testbench: point clustering block, loads and label reads against a label predictor
`timescale 1ns / 100ps
`default_nettype none
module dbscan_point_clustering_tb;
  import dbs_pkg::*;

  localparam longint CYCLE_LIMIT = 20000000;
  localparam int IN_W = $bits(in_item_t);

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we;
  logic cfg_index;
  logic [EPS_W-1:0] cfg_data;

  dbscan_point_clustering uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  int pt_x[MAX_POINTS];
  int pt_y[MAX_POINTS];
  int pt_z[MAX_POINTS];
  int pt_label[MAX_POINTS];
  int pt_count;
  int cluster_count;
  bit set_done;
  int eps_val;
  int min_nb;

  out_item_t label_fifo[$];
  int fail_count;
  longint cycle_count;
  int idle_pct;
  int item_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (label_fifo.size() == 0) begin
        report("label with no read pending");
      end else begin
        want = label_fifo.pop_front();
        if (out_item.point_label !== want.point_label)
          report($sformatf("point_label %0d, want %0d", out_item.point_label,
                           want.point_label));
        if (out_item.cluster_total !== want.cluster_total)
          report($sformatf("cluster_total %0d, want %0d", out_item.cluster_total,
                           want.cluster_total));
      end
    end
  end

  function automatic bit is_close(int a, int b);
    longint dx, dy, dz, e;
    dx = pt_x[a] - pt_x[b];
    dy = pt_y[a] - pt_y[b];
    dz = pt_z[a] - pt_z[b];
    e = eps_val;
    return (dx * dx + dy * dy + dz * dz) <= e * e;
  endfunction

  function automatic int close_count(int p);
    int c;
    c = 0;
    for (int k = 0; k < pt_count; k++) if (is_close(p, k)) c++;
    return c;
  endfunction

  function automatic void grab_close(int p, int id, ref int pend[$]);
    for (int k = 0; k < pt_count; k++) begin
      if (pt_label[k] == 0 && is_close(p, k)) begin
        pt_label[k] = id;
        pend.insert(pend.size(), k);
      end
    end
  endfunction

  function automatic void form_clusters();
    int id;
    int pend[$];
    int q;
    id = 1;
    for (int i = 0; i < pt_count; i++) pt_label[i] = 0;
    for (int i = 0; i < pt_count; i++) begin
      if (pt_label[i] != 0) continue;
      if (close_count(i) < min_nb) begin
        pt_label[i] = -1;
        continue;
      end
      pt_label[i] = id;
      pend.delete();
      grab_close(i, id, pend);
      while (pend.size() > 0) begin
        q = pend.pop_front();
        if (close_count(q) >= min_nb) grab_close(q, id, pend);
      end
      id++;
    end
    cluster_count = id - 1;
    set_done = 1'b1;
  endfunction

  function automatic void predict(in_item_t it);
    out_item_t r;
    if (it.command == CMD_LOAD) begin
      if (set_done) begin
        pt_count = 0;
        set_done = 1'b0;
      end
      if (pt_count < MAX_POINTS) begin
        pt_x[pt_count] = int'(it.coord_x);
        pt_y[pt_count] = int'(it.coord_y);
        pt_z[pt_count] = int'(it.coord_z);
        pt_label[pt_count] = 0;
        pt_count++;
      end
      if (it.final_point) form_clusters();
    end else begin
      r.point_label = LABEL_W'((it.read_index < pt_count) ? pt_label[it.read_index] : 0);
      r.cluster_total = TOT_W'(cluster_count);
      label_fifo.insert(label_fifo.size(), r);
    end
  endfunction

  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict(it);
    item_count++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic send_load(input int x, input int y, input int z, input bit fin);
    in_item_t it;
    it = IN_W'({$urandom, $urandom});
    it.command = CMD_LOAD;
    it.coord_x = COORD_W'(x);
    it.coord_y = COORD_W'(y);
    it.coord_z = COORD_W'(z);
    it.final_point = fin;
    send_item(it);
  endtask

  task automatic send_read(input int idx);
    in_item_t it;
    it = IN_W'({$urandom, $urandom});
    it.command = CMD_READ;
    it.read_index = RIDX_W'(idx);
    send_item(it);
  endtask

  // drain labels and let any clustering run finish
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (label_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= EPS_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EPS) eps_val = val & 16'hFFFF;
    else min_nb = val & 11'h7FF;
  endtask

  task automatic test_directed();
    write_reg(REG_EPS, 256);
    write_reg(REG_MINNB, 2);
    send_load(0, 0, 0, 0);
    send_load(100, 0, 0, 0);
    send_read(0);
    send_read(1);
    send_load(32767, 32767, 32767, 0);
    send_load(-32768, -32768, -32768, 0);
    send_load(200, 50, 0, 1);
    for (int i = 0; i < 6; i++) send_read(i);
    send_read(1023);
    send_load(-32768, 32767, -32768, 0);
    send_read(0);
    send_read(3);
    send_load(32767, -32768, 32767, 1);
    send_read(0);
    send_read(1);
    write_reg(REG_EPS, 65535);
    write_reg(REG_MINNB, 1);
    send_load(-32768, -32768, -32768, 0);
    send_load(32767, 32767, 32767, 0);
    send_load(0, 0, 0, 1);
    for (int i = 0; i < 3; i++) send_read(i);
    write_reg(REG_EPS, 0);
    send_load(5, 5, 5, 0);
    send_load(5, 5, 5, 1);
    send_read(0);
    send_read(1);
  endtask

  task automatic random_set(input int n);
    int nc, c, spread;
    int cx[3], cy[3], cz[3];
    nc = $urandom_range(3, 1);
    spread = (eps_val > 2000) ? 4000 : 2 * eps_val + 2;
    for (int i = 0; i < nc; i++) begin
      cx[i] = $urandom;
      cy[i] = $urandom;
      cz[i] = $urandom;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_load($urandom, $urandom, $urandom, i == n - 1);
      end else begin
        c = $urandom_range(nc - 1);
        send_load(cx[c] + $urandom_range(2 * spread) - spread,
                  cy[c] + $urandom_range(2 * spread) - spread,
                  cz[c] + $urandom_range(2 * spread) - spread, i == n - 1);
      end
      if ($urandom_range(15) == 0) send_read($urandom_range(n));
    end
    repeat ($urandom_range(n + 3, 2)) begin
      if ($urandom_range(7) == 0) send_read($urandom);
      else send_read($urandom_range(n));
    end
  endtask

  task automatic test_random_sets();
    int base;
    int eps_pick[5];
    int nb_pick[5];
    eps_pick = '{0, 1, 256, 65535, 0};
    nb_pick = '{1, 2, 3, 1024, 0};
    base = item_count;
    for (int s = 0; item_count - base < 870; s++) begin
      idle_pct = (s % 4 == 0) ? 0 : (s % 4 == 3) ? 23 : 63;
      if (s % 3 == 0) begin
        eps_pick[4] = $urandom_range(2000);
        write_reg(REG_EPS, eps_pick[$urandom_range(4)]);
      end
      if (s % 3 == 1) begin
        nb_pick[4] = $urandom_range(6, 1);
        write_reg(REG_MINNB, nb_pick[$urandom_range(4)]);
      end
      if (s == 7) wait_idle();
      random_set($urandom_range(24, 1));
    end
  endtask

  task automatic test_capacity();
    idle_pct = 0;
    write_reg(REG_EPS, 0);
    write_reg(REG_MINNB, 1024);
    for (int i = 0; i < MAX_POINTS + 6; i++)
      send_load(i, -i, i >> 2, i == MAX_POINTS + 5);
    send_read(0);
    send_read(512);
    send_read(1023);
    write_reg(REG_MINNB, 1);
    send_load(1, 2, 3, 1);
    send_read(0);
    send_read(1);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    idle_pct = 0;
    item_count = 0;
    pt_count = 0;
    cluster_count = 0;
    set_done = 1'b0;
    eps_val = 256;
    min_nb = 10;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sets();
    test_capacity();
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/dbs_pkg.sv
hw/rtl/dbs_dist.sv
hw/rtl/dbs_engine.sv
hw/rtl/dbscan_point_clustering.sv
sim/dbscan_point_clustering_tb.sv
